### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication or any other property, sampled on clk, off during reset.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("invariant violated");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, rst_n, cond)

`endif

`endif

### design/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants of the line substring matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int unsigned PATTERN_MAX_DEF   = 16;
  localparam int unsigned LINE_CAPACITY_DEF = 2000;

  // Pattern storage is fixed at 16 bytes by the register map
  localparam int unsigned PAT_BYTES  = 16;
  localparam int unsigned PAT_W      = 8 * PAT_BYTES;
  localparam int unsigned LEN_W      = 5;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;

  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2,
    REG_INVERT  = 2'd3
  } lsm_reg_e;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
    logic             invert;
  } lsm_cfg_t;

endpackage

`default_nettype wire

### design/lsm_cell.sv
// ----------------------------------------------------------------------------
// lsm_cell
// One byte of the text window: holds a byte and its in-line flag, passes
// both to the next cell on every byte beat and compares the incoming byte
// against the pattern byte that lines up with this position.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       shift_i,
  input  wire logic                       clear_i,
  input  wire logic [7:0]                 byte_i,
  input  wire logic                       vld_i,
  input  wire logic [lsm_pkg::PAT_W-1:0]  pattern_i,
  input  wire logic [lsm_pkg::LEN_W-1:0]  len_i,
  output      logic [7:0]                 byte_o,
  output      logic                       vld_o,
  output      logic                       hit_o
);
  import lsm_pkg::*;

  localparam logic [LEN_W-1:0] K = LEN_W'(CellIdx);

  logic [7:0]       byte_q;
  logic             vld_q, vld_d;
  logic [LEN_W-1:0] pos;
  logic [3:0]       pat_idx;
  logic [7:0]       exp_byte;
  logic             in_use;

  // newest byte sits in cell 0 and lines up with the last pattern byte
  assign pos      = len_i - LEN_W'(1) - K;
  assign pat_idx  = pos[3:0];
  assign exp_byte = pattern_i[{pat_idx, 3'b000} +: 8];
  assign in_use   = (K < len_i);
  assign hit_o    = !in_use || (vld_i && (byte_i == exp_byte));

  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (shift_i) begin
      vld_d = vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

endmodule

`default_nettype wire

### design/lsm_cfg.sv
// ----------------------------------------------------------------------------
// lsm_cfg
// APB register file: pattern words, pattern length and invert.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lsm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lsm_pkg::APB_DATA_W-1:0]  pwdata,
  output      logic [lsm_pkg::APB_DATA_W-1:0]  prdata,
  output      logic                            pready,
  output      lsm_pkg::lsm_cfg_t               cfg_o
);
  import lsm_pkg::*;

  logic [63:0]      pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0] len_q;
  logic             inv_q;
  logic             wr_en;
  lsm_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = lsm_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      inv_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PAT_LO:  pat_lo_q <= pwdata;
        REG_PAT_HI:  pat_hi_q <= pwdata;
        REG_PAT_LEN: len_q    <= pwdata[LEN_W-1:0];
        REG_INVERT:  inv_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAT_LO:  prdata = pat_lo_q;
      REG_PAT_HI:  prdata = pat_hi_q;
      REG_PAT_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, len_q};
      REG_INVERT:  prdata = {{(APB_DATA_W-1){1'b0}}, inv_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.length  = len_q;
  assign cfg_o.invert  = inv_q;

endmodule

`default_nettype wire

### design/line_substring_matcher_top.sv
// ----------------------------------------------------------------------------
// line_substring_matcher_top
// Per-line substring match over a byte stream, one result beat per line.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the result side keeps up; a result
// held by a stalled receiver blocks the input until that result is taken.
// A result is registered and shows on the output in the cycle after the beat that
// ends its line (newline, full line, or end-of-stream flush).
// The window compare is one row of PATTERN_MAX cells fed by each byte beat.
// Reset clears window valid flags, line state, line count and registers.
`default_nettype none

module line_substring_matcher_top #(
  parameter int unsigned PATTERN_MAX   = lsm_pkg::PATTERN_MAX_DEF,
  parameter int unsigned LINE_CAPACITY = lsm_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] ch
  input  wire logic                            s_axis_tuser,  // [0] end_of_stream
  // result stream
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] line_number, [32] selected, [33] any_selected, [39:34] zero
  output      logic [lsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lsm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lsm_pkg::APB_DATA_W-1:0]  pwdata,
  output      logic [lsm_pkg::APB_DATA_W-1:0]  prdata,
  output      logic                            pready
);
  import lsm_pkg::*;

  localparam int unsigned FILL_W = $clog2(LINE_CAPACITY);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(LINE_CAPACITY - 1);
  localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(PATTERN_MAX);

  lsm_cfg_t cfg;

  lsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [LEN_W-1:0] act_len;
  assign act_len = (cfg.length > LEN_CAP) ? LEN_CAP : cfg.length;

  logic in_beat, byte_beat, eos_beat, finish;

  // ---- window cell row ----
  logic [7:0]             byte_chain [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] vld_chain;
  logic [PATTERN_MAX-1:0] hit;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] b_in;
    logic       v_in;
    if (k == 0) begin : g_head
      assign b_in = s_axis_tdata;
      assign v_in = 1'b1;
    end else begin : g_body
      assign b_in = byte_chain[k-1];
      assign v_in = vld_chain[k-1];
    end
    lsm_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (byte_beat),
      .clear_i   (finish),
      .byte_i    (b_in),
      .vld_i     (v_in),
      .pattern_i (cfg.pattern),
      .len_i     (act_len),
      .byte_o    (byte_chain[k]),
      .vld_o     (vld_chain[k]),
      .hit_o     (hit[k])
    );
  end

  // ---- line control ----
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic              line_hit_q, line_hit_d;
  logic [31:0]       count_q, count_d, count_next;
  logic              found_q, found_d, found_next;
  logic              hit_now, sel;
  logic              m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign byte_beat     = in_beat && !s_axis_tuser;
  assign eos_beat      = in_beat && s_axis_tuser;

  assign fill_inc   = fill_q + FILL_W'(1);
  assign hit_now    = byte_beat && (act_len != '0) && (&hit);
  assign finish     = (byte_beat && ((s_axis_tdata == NEWLINE) || (fill_inc == FILL_LAST)))
                   || (eos_beat && (fill_q != '0));

  assign sel        = ((line_hit_q || hit_now) || (act_len == '0)) ^ cfg.invert;
  assign count_next = (&count_q) ? count_q : count_q + 32'd1;
  assign found_next = found_q || sel;

  always_comb begin
    fill_d     = fill_q;
    line_hit_d = line_hit_q;
    count_d    = count_q;
    found_d    = found_q;
    if (finish) begin
      fill_d     = '0;
      line_hit_d = 1'b0;
      count_d    = count_next;
      found_d    = found_next;
    end else if (byte_beat) begin
      fill_d     = fill_inc;
      line_hit_d = line_hit_q || hit_now;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (finish) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      line_hit_q <= 1'b0;
      count_q    <= '0;
      found_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      line_hit_q <= line_hit_d;
      count_q    <= count_d;
      found_q    <= found_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      m_data_q <= {{(OUT_DATA_W-34){1'b0}}, found_next, sel, count_next};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---- assertions ----
`include "assert_macros.svh"

  // window head flag tracks the line fill count
  `ASSERT_ALWAYS(a_fill_vs_head, clk_i, rst_ni, ((fill_q != '0) == vld_chain[0]))
  // a finished line always lands in the output register
  `ASSERT_PROP(a_finish_out, clk_i, rst_ni, finish |=> m_valid_q)
  // sticky any-selected flag never drops
  `ASSERT_PROP(a_found_sticky, clk_i, rst_ni, found_q |=> found_q)
  // a pending result carries a nonzero line number
  `ASSERT_PROP(a_line_num, clk_i, rst_ni, m_valid_q |-> (m_data_q[31:0] != 32'd0))

endmodule

`default_nettype wire
